>>> rtl/fix_tag_value_field_parser_top_assert.svh
// assertion macros for the field parser checker
`ifndef FIX_TAG_VALUE_FIELD_PARSER_TOP_ASSERT_SVH
`define FIX_TAG_VALUE_FIELD_PARSER_TOP_ASSERT_SVH
// implication checked on every clock edge outside reset
`define FTV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define FTV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> rtl/ftvp_pkg.sv
// ---------------------------------------------------------------------------
// ftvp_pkg
// shared types and constants of the tag=value field parser
// ---------------------------------------------------------------------------
package ftvp_pkg;
	localparam int MaxFields   = 128;
	localparam int TableTags   = 1024;
	localparam int MaxMsgBytes = 4096;
	localparam int TabAw       = $clog2(TableTags);
	localparam int PosW        = $clog2(MaxMsgBytes) + 1;

	localparam logic [7:0] SohByte = 8'h01;
	localparam logic [7:0] EqByte  = 8'h3d;
	localparam logic [PosW-1:0] MinMsgBytes = PosW'(20);
	localparam logic [16:0] TagLimit = 17'd65535;

	localparam logic [1:0] KIND_FIELD   = 2'd0;
	localparam logic [1:0] KIND_VERDICT = 2'd1;
	localparam logic [1:0] KIND_LOOKUP  = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD      = 2'd1;
	localparam logic [1:0] ST_NOFIELDS = 2'd2;
	localparam logic [1:0] ST_TOOLONG  = 2'd3;

	typedef struct packed {
		logic        action;
		logic [7:0]  data_byte;
		logic        end_of_message;
		logic [15:0] query_tag;
	} in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] field_tag;
		logic [11:0] value_offset;
		logic [11:0] value_length;
		logic [7:0]  field_index;
		logic [1:0]  status;
		logic        found;
		logic        last_of_run;
	} out_t;

	// classified work handed from front to back
	typedef struct packed {
		logic        lookup;      // lookup beat
		logic        lk_ok;       // lookup allowed (good, idle, in range)
		logic [15:0] tag;
		logic        wr;          // field closed
		logic        emit_field;
		logic [11:0] off;
		logic [11:0] len;
		logic [7:0]  idx;
		logic [15:0] gen;
		logic        verdict;
		logic [1:0]  status;
		logic [7:0]  count;
		logic        wipe;        // generation wrapped
	} op_t;

	function automatic logic [7:0] prefix_char(input logic [2:0] i);
		logic [7:0] c;
		case (i)
			3'd0: c = 8'h38;
			3'd1: c = 8'h3d;
			3'd2: c = 8'h46;
			3'd3: c = 8'h49;
			default: c = 8'h58;
		endcase
		return c;
	endfunction
endpackage

>>> rtl/ftvp_front.sv
// ---------------------------------------------------------------------------
// ftvp_front
// byte parser: tracks tag/value state and classifies each beat into an op
// ---------------------------------------------------------------------------
module ftvp_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid,
	output logic           stall,
	input  ftvp_pkg::in_t  data,
	output logic           op_valid,
	input  logic           op_full,
	output ftvp_pkg::op_t  op
);
	localparam int PW = ftvp_pkg::PosW;

	logic        open_q, inval_q;
	logic [16:0] tag_q;
	logic        hasd_q, dend_q;
	logic [PW-1:0] pos_q;
	logic [11:0] vstart_q;
	logic [7:0]  cnt_q;
	logic        pfx_q, stop_q, long_q, good_q;
	logic [15:0] gen_q;

	logic          acc, is_byte, fresh;
	logic [16:0]   tag_b;
	logic [16:0]   tag_c;
	logic          hasd_c, dend_c, inval_c, stop_c, long_c, pfx_c;
	logic [PW-1:0] pos_c;
	logic [11:0]   vstart_c;
	logic [7:0]    cnt_c;
	logic [15:0]   gen_c;
	logic [7:0]    b;
	logic [20:0]   mul;
	logic [1:0]    st;

	assign stall = op_full;
	assign acc = valid && !op_full;
	assign op_valid = acc;
	assign is_byte = !data.action;
	assign fresh = is_byte && !open_q;
	assign b = data.data_byte;
	// tag accumulator as seen by this beat, cleared when a message opens
	assign tag_b = fresh ? '0 : tag_q;
	assign mul = {tag_b, 3'b000} + {2'b00, tag_b, 1'b0} + 21'(b - 8'h30);

	// next state of the parser for this beat
	always_comb begin
		op = '0;
		op.lookup = data.action;
		op.tag = data.query_tag;
		op.lk_ok = good_q && !open_q &&
			(32'(data.query_tag) < ftvp_pkg::TableTags);
		tag_c = tag_b;
		hasd_c = fresh ? 1'b0 : hasd_q;
		dend_c = fresh ? 1'b0 : dend_q;
		inval_c = fresh ? 1'b0 : inval_q;
		pos_c = fresh ? '0 : pos_q;
		vstart_c = fresh ? '0 : vstart_q;
		cnt_c = fresh ? '0 : cnt_q;
		pfx_c = fresh ? 1'b1 : pfx_q;
		stop_c = fresh ? 1'b0 : stop_q;
		long_c = fresh ? 1'b0 : long_q;
		gen_c = fresh ? gen_q + 16'd1 : gen_q;
		op.wipe = fresh && (gen_c == '0);
		op.gen = gen_c;
		if (is_byte) begin
			if (32'(pos_c) >= ftvp_pkg::MaxMsgBytes) begin
				long_c = 1'b1;
				stop_c = 1'b1;
			end else begin
				if (pos_c < PW'(5) &&
					b != ftvp_pkg::prefix_char(pos_c[2:0]))
					pfx_c = 1'b0;
				if (!stop_c) begin
					if (!inval_c) begin
						if (b == ftvp_pkg::EqByte) begin
							if (hasd_c && tag_c <= ftvp_pkg::TagLimit) begin
								inval_c = 1'b1;
								vstart_c = 12'(pos_c + PW'(1));
							end else begin
								stop_c = 1'b1;
							end
						end else if (b >= 8'h30 && b <= 8'h39 && !dend_c) begin
							tag_c = (mul > 21'(ftvp_pkg::TagLimit)) ?
								17'h10000 : mul[16:0];
							hasd_c = 1'b1;
						end else begin
							dend_c = 1'b1;
						end
					end else if (b == ftvp_pkg::SohByte) begin
						op.wr = 1'b1;
						op.emit_field = pfx_c;
						op.tag = tag_c[15:0];
						op.off = vstart_c;
						op.len = 12'(pos_c) - vstart_c;
						op.idx = cnt_c;
						cnt_c = cnt_c + 8'd1;
						tag_c = '0;
						hasd_c = 1'b0;
						dend_c = 1'b0;
						inval_c = 1'b0;
						if (32'(cnt_c) >= ftvp_pkg::MaxFields)
							stop_c = 1'b1;
					end
				end
				pos_c = pos_c + PW'(1);
			end
			if (data.end_of_message) begin
				if (pos_c < ftvp_pkg::MinMsgBytes || !pfx_c)
					st = ftvp_pkg::ST_BAD;
				else if (long_c)
					st = ftvp_pkg::ST_TOOLONG;
				else if (cnt_c == '0)
					st = ftvp_pkg::ST_NOFIELDS;
				else
					st = ftvp_pkg::ST_OK;
				op.verdict = 1'b1;
				op.status = st;
				op.count = cnt_c;
			end else begin
				st = ftvp_pkg::ST_OK;
			end
		end else begin
			st = ftvp_pkg::ST_OK;
		end
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0; inval_q <= 1'b0; tag_q <= '0; hasd_q <= 1'b0;
			dend_q <= 1'b0; pos_q <= '0; vstart_q <= '0; cnt_q <= '0;
			pfx_q <= 1'b1; stop_q <= 1'b0; long_q <= 1'b0; good_q <= 1'b0;
			gen_q <= '0;
		end else if (acc && is_byte) begin
			tag_q <= tag_c; hasd_q <= hasd_c; dend_q <= dend_c;
			pos_q <= pos_c; vstart_q <= vstart_c; cnt_q <= cnt_c;
			pfx_q <= pfx_c; stop_q <= stop_c; long_q <= long_c;
			gen_q <= gen_c;
			open_q <= !data.end_of_message;
			inval_q <= data.end_of_message ? 1'b0 : inval_c;
			good_q <= data.end_of_message && (st == ftvp_pkg::ST_OK);
		end
	end
endmodule

>>> rtl/ftvp_back.sv
// ---------------------------------------------------------------------------
// ftvp_back
// tag table, table-read stage and result output queue
// ---------------------------------------------------------------------------
module ftvp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           op_valid,
	output logic           op_full,
	input  ftvp_pkg::op_t  op,
	output logic           valid,
	input  logic           stall,
	output ftvp_pkg::out_t data
);
	localparam int AW = ftvp_pkg::TabAw;
	localparam int TT = ftvp_pkg::TableTags;

	// table memory: valid, generation, offset, length
	logic [40:0]   mem [TT];

	// clearing pass over the table after reset and on generation wrap
	logic          clr_q;
	logic [AW-1:0] clr_idx_q;

	// stage 1: op after table read
	logic          s1_v_s1;
	ftvp_pkg::op_t op_s1;
	logic [40:0]   rd_s1;

	// output queue of results, depth 4
	ftvp_pkg::out_t q_mem [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	logic [AW-1:0] ra, wa;
	logic          s1_go, hit;
	logic [1:0]    n_push;
	ftvp_pkg::out_t r0, r1;

	assign ra = op.tag[AW-1:0];
	assign wa = op.tag[AW-1:0];
	// a new op may push two results once the stage ahead has pushed its own
	assign op_full = clr_q || ((cnt_q + {1'b0, n_push}) > 3'd2);
	assign s1_go = op_valid;

	// table read and write
	always_ff @(posedge clk) begin
		rd_s1 <= mem[ra];
		if (clr_q)
			mem[clr_idx_q] <= '0;
		else if (op_valid && op.wr && (32'(op.tag) < TT))
			mem[wa] <= {1'b1, op.gen, op.off, op.len};
	end

	// clearing pass control and stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_idx_q <= '0;
			s1_v_s1 <= 1'b0;
		end else begin
			s1_v_s1 <= s1_go;
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + AW'(1);
				if (clr_idx_q == AW'(TT - 1))
					clr_q <= 1'b0;
			end else if (op_valid && op.wipe) begin
				clr_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= op;
	end

	// build results
	always_comb begin
		hit = op_s1.lk_ok && rd_s1[40] && (rd_s1[39:24] == op_s1.gen) &&
			(rd_s1[11:0] != '0);
		r0 = '0;
		r1 = '0;
		n_push = 2'd0;
		if (op_s1.lookup) begin
			r0.kind = ftvp_pkg::KIND_LOOKUP;
			r0.field_tag = op_s1.tag;
			r0.found = hit;
			r0.value_offset = hit ? rd_s1[23:12] : '0;
			r0.value_length = hit ? rd_s1[11:0] : '0;
			r0.last_of_run = 1'b1;
			n_push = 2'd1;
		end else begin
			if (op_s1.wr && op_s1.emit_field) begin
				r0.kind = ftvp_pkg::KIND_FIELD;
				r0.field_tag = op_s1.tag;
				r0.value_offset = op_s1.off;
				r0.value_length = op_s1.len;
				r0.field_index = op_s1.idx;
				r0.last_of_run = !op_s1.verdict;
				n_push = 2'd1;
			end
			if (op_s1.verdict) begin
				r1.kind = ftvp_pkg::KIND_VERDICT;
				r1.field_index = op_s1.count;
				r1.status = op_s1.status;
				r1.last_of_run = 1'b1;
				if (n_push == 2'd0) begin
					r0 = r1;
					n_push = 2'd1;
				end else begin
					n_push = 2'd2;
				end
			end
		end
		if (!s1_v_s1)
			n_push = 2'd0;
	end

	logic pop;
	assign valid = (cnt_q != '0);
	assign data = q_mem[rp_q];
	assign pop = valid && !stall;

	always_ff @(posedge clk) begin
		if (n_push != 2'd0)
			q_mem[wp_q] <= r0;
		if (n_push == 2'd2)
			q_mem[wp_q + 2'd1] <= r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + n_push;
			rp_q <= rp_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, n_push} - {2'b00, pop};
		end
	end
endmodule

>>> rtl/fix_tag_value_field_parser_top.sv
// a beat's results pass the table-read stage and the output queue before they are offered
// throughput: one beat per cycle while in_stall is low; a beat yields up to two results
// input is held while queued results plus those being written exceed two
// reset: asynchronous active low; a clearing pass over every entry empties the tag
// table after reset and again when the message generation wraps, input held
// ---------------------------------------------------------------------------
// fix_tag_value_field_parser_top
// tag=value field parser with per-tag value table
// ---------------------------------------------------------------------------
module fix_tag_value_field_parser_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  ftvp_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output ftvp_pkg::out_t out_data
);
	logic          op_valid, op_full;
	ftvp_pkg::op_t op;

	// front: parse and classify
	ftvp_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .stall(in_stall),
		.data(in_data), .op_valid(op_valid), .op_full(op_full), .op(op)
	);

	// back: table and results
	ftvp_back u_back (
		.clk(clk), .arst_n(arst_n), .op_valid(op_valid), .op_full(op_full),
		.op(op), .valid(out_valid), .stall(out_stall), .data(out_data)
	);
endmodule

>>> rtl/ftvp_checker.sv
// ---------------------------------------------------------------------------
// ftvp_checker
// port-level checks of the field parser
// ---------------------------------------------------------------------------
`include "fix_tag_value_field_parser_top_assert.svh"
module ftvp_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input ftvp_pkg::in_t  in_data,
	input logic           out_valid,
	input logic           out_stall,
	input ftvp_pkg::out_t out_data
);
	`FTV_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))
	`FTV_ASSERT_IMP(a_kind, clk, arst_n, out_valid, out_data.kind != 2'd3)
	`FTV_ASSERT_IMP(a_found, clk, arst_n, out_valid && out_data.found, out_data.kind == ftvp_pkg::KIND_LOOKUP)
	`FTV_ASSERT_IMP(a_vlast, clk, arst_n, out_valid && out_data.kind == ftvp_pkg::KIND_VERDICT, out_data.last_of_run)
endmodule

bind fix_tag_value_field_parser_top ftvp_checker u_chk (.*);

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the tag=value field parser: whole messages with
// random fields, broken and noisy messages and tag lookups are streamed in,
// and every result beat is checked against a predicted field list
// ---------------------------------------------------------------------------

// keeps the parser state and the queue of predicted result beats
class field_scoreboard;
	localparam int PhIdle  = 0;
	localparam int PhTag   = 1;
	localparam int PhValue = 2;

	int          phase;
	int unsigned tag_acc;
	bit          has_digit;
	bit          digits_ended;
	int unsigned pos_count;
	int unsigned val_start;
	int unsigned field_cnt;
	bit          prefix_good;
	bit          stopped;
	bit          overflow;
	int unsigned gen;
	bit          msg_good;
	bit          tv_valid [ftvp_pkg::TableTags];
	bit   [15:0] tv_gen   [ftvp_pkg::TableTags];
	bit   [11:0] tv_off   [ftvp_pkg::TableTags];
	bit   [11:0] tv_len   [ftvp_pkg::TableTags];

	ftvp_pkg::out_t pending_results[$];
	int mismatches;

	function new();
		phase = PhIdle;
		tag_acc = 0;
		has_digit = 0;
		digits_ended = 0;
		pos_count = 0;
		val_start = 0;
		field_cnt = 0;
		prefix_good = 1;
		stopped = 0;
		overflow = 0;
		gen = 0;
		msg_good = 0;
		mismatches = 0;
		foreach (tv_valid[i]) begin
			tv_valid[i] = 0;
			tv_gen[i] = '0;
			tv_off[i] = '0;
			tv_len[i] = '0;
		end
	endfunction

	function void push(logic [1:0] kind, int unsigned tag, int unsigned off,
			int unsigned len, int unsigned idx, logic [1:0] st, bit fnd, bit last);
		ftvp_pkg::out_t r;
		r.kind = kind;
		r.field_tag = tag[15:0];
		r.value_offset = off[11:0];
		r.value_length = len[11:0];
		r.field_index = idx[7:0];
		r.status = st;
		r.found = fnd;
		r.last_of_run = last;
		pending_results.push_back(r);
	endfunction

	function void clear_tag();
		tag_acc = 0;
		has_digit = 0;
		digits_ended = 0;
	endfunction

	// predict the results of one accepted input beat
	function void note_input(ftvp_pkg::in_t b);
		int unsigned p;
		int unsigned t;
		int unsigned len;
		logic [7:0] c;
		logic [1:0] st;
		bit hit;
		int unsigned q;
		c = b.data_byte;
		q = b.query_tag;
		// lookup
		if (b.action) begin
			hit = (q < ftvp_pkg::TableTags) && msg_good && phase == PhIdle;
			if (hit)
				hit = tv_valid[q] && tv_gen[q] == gen[15:0] && tv_len[q] != 0;
			push(ftvp_pkg::KIND_LOOKUP, q, hit ? tv_off[q] : 0,
				hit ? tv_len[q] : 0, 0, ftvp_pkg::ST_OK, hit, 1'b1);
			return;
		end
		// message open
		if (phase == PhIdle) begin
			gen = (gen + 1) & 16'hffff;
			if (gen == 0)
				foreach (tv_valid[i]) tv_valid[i] = 0;
			msg_good = 0;
			clear_tag();
			pos_count = 0;
			val_start = 0;
			field_cnt = 0;
			prefix_good = 1;
			stopped = 0;
			overflow = 0;
			phase = PhTag;
		end
		p = pos_count;
		if (p >= ftvp_pkg::MaxMsgBytes) begin
			overflow = 1;
			stopped = 1;
		end else begin
			pos_count = p + 1;
			if (p < 5 && c != ftvp_pkg::prefix_char(p[2:0]))
				prefix_good = 0;
			if (!stopped) begin
				if (phase == PhTag) begin
					if (c == ftvp_pkg::EqByte) begin
						if (has_digit && tag_acc <= 65535) begin
							phase = PhValue;
							val_start = p + 1;
						end else
							stopped = 1;
					end else if (c >= "0" && c <= "9" && !digits_ended) begin
						t = tag_acc * 10 + (c - "0");
						tag_acc = (t > 65535) ? 65536 : t;
						has_digit = 1;
					end else
						digits_ended = 1;
				end else if (c == ftvp_pkg::SohByte) begin
					len = p - val_start;
					if (prefix_good)
						push(ftvp_pkg::KIND_FIELD, tag_acc, val_start, len, field_cnt,
							ftvp_pkg::ST_OK, 0, !b.end_of_message);
					if (tag_acc < ftvp_pkg::TableTags) begin
						tv_valid[tag_acc] = 1;
						tv_gen[tag_acc] = gen[15:0];
						tv_off[tag_acc] = val_start[11:0];
						tv_len[tag_acc] = len[11:0];
					end
					field_cnt++;
					clear_tag();
					phase = PhTag;
					if (field_cnt >= ftvp_pkg::MaxFields)
						stopped = 1;
				end
			end
		end
		// verdict
		if (b.end_of_message) begin
			if (pos_count < 20 || !prefix_good)
				st = ftvp_pkg::ST_BAD;
			else if (overflow)
				st = ftvp_pkg::ST_TOOLONG;
			else if (field_cnt == 0)
				st = ftvp_pkg::ST_NOFIELDS;
			else
				st = ftvp_pkg::ST_OK;
			push(ftvp_pkg::KIND_VERDICT, 0, 0, 0, field_cnt, st, 0, 1'b1);
			msg_good = (st == ftvp_pkg::ST_OK);
			phase = PhIdle;
		end
	endfunction

	// compare one result beat with the oldest prediction
	function void check_result(ftvp_pkg::out_t got);
		ftvp_pkg::out_t exp_r;
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result beat %h", got);
			return;
		end
		exp_r = pending_results.pop_front();
		if (got !== exp_r) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result mismatch: expected %h actual %h", exp_r, got);
		end
	endfunction
endclass

module tb_top;
	logic           clk;
	logic           arst_n;
	logic           in_valid;
	logic           in_stall;
	ftvp_pkg::in_t  in_data;
	logic           out_valid;
	logic           out_stall;
	ftvp_pkg::out_t out_data;

	localparam int WatchdogLimit = 20000;

	field_scoreboard sb;
	int  idle_cycles;
	bit  timed_out;
	int  stall_mode;
	int  burst_left;

	// byte stream under construction
	logic [7:0] msg_bytes[$];

	fix_tag_value_field_parser_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// scoreboard, receiver stalls and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_input(in_data);
			if (out_valid && !out_stall)
				sb.check_result(out_data);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if ($urandom_range(0, 199) == 0)
				stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 1) == 0);
				default: out_stall <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// send one beat, with bursts and gaps on the sender side
	task automatic send_beat(input ftvp_pkg::in_t b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_byte(input logic [7:0] c, input bit last);
		ftvp_pkg::in_t b;
		b.action = 1'b0;
		b.data_byte = c;
		b.end_of_message = last;
		b.query_tag = 16'($urandom);
		send_beat(b);
	endtask

	task automatic send_lookup(input logic [15:0] q);
		ftvp_pkg::in_t b;
		b.action = 1'b1;
		b.data_byte = 8'($urandom);
		b.end_of_message = 1'($urandom);
		b.query_tag = q;
		send_beat(b);
	endtask

	// send the queued message bytes, marking the last
	task automatic flush_message();
		int n;
		n = msg_bytes.size();
		for (int i = 0; i < n; i++)
			send_byte(msg_bytes[i], i == n - 1);
		msg_bytes.delete();
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			msg_bytes.push_back(s[i]);
	endtask

	task automatic add_number(input int unsigned v);
		add_text($sformatf("%0d", v));
	endtask

	// one well-formed field with a random tag, mostly below 1024, and a short value
	task automatic append_field();
		int unsigned tag;
		int n;
		case ($urandom_range(0, 9))
			0: tag = $urandom_range(1024, 65535);
			1: tag = $urandom_range(0, 15);
			default: tag = $urandom_range(0, 1023);
		endcase
		add_number(tag);
		msg_bytes.push_back(ftvp_pkg::EqByte);
		n = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8);
		repeat (n) msg_bytes.push_back(8'($urandom_range(32, 255)));
		msg_bytes.push_back(ftvp_pkg::SohByte);
	endtask

	// well-formed message with random fields, sometimes broken
	task automatic random_message();
		int nf;
		add_text("8=FIX.4.4");
		msg_bytes.push_back(ftvp_pkg::SohByte);
		add_text("9=");
		add_number($urandom_range(10, 99));
		msg_bytes.push_back(ftvp_pkg::SohByte);
		nf = $urandom_range(1, 6);
		repeat (nf) append_field();
		case ($urandom_range(0, 9))
			0: msg_bytes[$urandom_range(0, 4)] = 8'($urandom);
			1: msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom);
			2: add_text("-5=x");
			3: begin
				add_text("12a9=");
				msg_bytes.push_back(ftvp_pkg::SohByte);
			end
			default: ;
		endcase
		flush_message();
	endtask

	initial begin
		int sent;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		idle_cycles = 0;
		timed_out = 0;
		stall_mode = 0;
		burst_left = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: lookup before any message, short bad message
		send_lookup(16'd0);
		send_lookup(16'hffff);
		add_text("8=FIX");
		flush_message();
		// no fields, good prefix
		add_text("8=FIXxxxxxxxxxxxxxxxxxxxx");
		flush_message();
		// good message, empty value, extremes of tag
		add_text("8=FIX.4.2");
		msg_bytes.push_back(ftvp_pkg::SohByte);
		add_text("0=");
		msg_bytes.push_back(ftvp_pkg::SohByte);
		add_text("1023=abc");
		msg_bytes.push_back(ftvp_pkg::SohByte);
		add_text("65535=z");
		msg_bytes.push_back(ftvp_pkg::SohByte);
		flush_message();
		send_lookup(16'd0);
		send_lookup(16'd1023);
		send_lookup(16'd1024);
		send_lookup(16'd9);
		// tag over limit and no-digit tag
		add_text("8=FIX.4.4");
		msg_bytes.push_back(ftvp_pkg::SohByte);
		add_text("65536=q");
		msg_bytes.push_back(ftvp_pkg::SohByte);
		add_text("35=D");
		msg_bytes.push_back(ftvp_pkg::SohByte);
		flush_message();
		add_text("8=FIX.4.4");
		msg_bytes.push_back(ftvp_pkg::SohByte);
		add_text("=oops");
		msg_bytes.push_back(ftvp_pkg::SohByte);
		add_text("..........");
		flush_message();
		// field limit: more than MaxFields fields
		add_text("8=FIX");
		msg_bytes.push_back(ftvp_pkg::SohByte);
		repeat (ftvp_pkg::MaxFields + 3) begin
			add_text("7=v");
			msg_bytes.push_back(ftvp_pkg::SohByte);
		end
		flush_message();
		send_lookup(16'd7);
		// too long: beyond MaxMsgBytes
		add_text("8=FIX");
		msg_bytes.push_back(ftvp_pkg::SohByte);
		add_text("58=");
		repeat (ftvp_pkg::MaxMsgBytes) msg_bytes.push_back(8'h41);
		msg_bytes.push_back(ftvp_pkg::SohByte);
		flush_message();
		send_lookup(16'd58);

		// random part
		sent = 0;
		while (sent < 1100) begin
			case ($urandom_range(0, 9))
				0: begin
					repeat ($urandom_range(1, 30)) begin
						msg_bytes.push_back(8'($urandom));
						sent++;
					end
					flush_message();
				end
				1, 2: begin
					send_lookup(($urandom_range(0, 9) == 0) ? 16'($urandom)
						: 16'($urandom_range(0, 1023)));
					sent++;
				end
				default: begin
					sent += 40;
					random_message();
					repeat ($urandom_range(0, 3)) send_lookup(16'($urandom_range(0, 1023)));
				end
			endcase
		end
		in_valid <= 1'b0;

		// drain
		while (sb.pending_results.size() != 0 && !timed_out) @(posedge clk);
		repeat (20) @(posedge clk);
		if (timed_out || sb.mismatches != 0 || sb.pending_results.size() != 0)
			$display("Verification failed");
		else
			$display("Verification passed");
		$finish;
	end

	// watchdog
	always @(posedge clk) begin
		if (idle_cycles >= WatchdogLimit && !timed_out) begin
			timed_out = 1;
			$display("Verification failed");
			$finish;
		end
	end
endmodule
